// ===== rtl/core/worker_pool_allocator_unit_assert.svh =====
// Assertion macros for the worker pool allocator unit.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef WORKER_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define WORKER_POOL_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define WPA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define WPA_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define WPA_ASSERT(name, prop)
`define WPA_ASSERT_NEVER(name, cond)
`endif

`endif

// ===== rtl/core/wpa_pkg.sv =====
// Shared types and constants of the worker pool allocator unit.
// Used by the controller, the datapath and the top level.
package wpa_pkg;

  localparam int unsigned MAX_WORKERS_DEF = 32;
  localparam int unsigned CFG_W = 6;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam logic [CFG_W-1:0] WORKER_COUNT_RST = 6'd32;

  localparam logic REQ_RELEASE = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMPTY,
    ST_SYNC
  } wpa_state_e;

  typedef struct packed {
    logic cfg_write;
    logic sync_step;
    logic release_slot;
    logic load_req;
    logic scan;
    logic emit_empty;
  } wpa_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic grant_last;
    logic sync_last;
    logic can_load;
  } wpa_status_t;

endpackage

// ===== rtl/core/wpa_ctrl.sv =====
// Controller state machine of the worker pool allocator unit.
// Depends on wpa_pkg; drives the datapath wpa_dp through command signals.
module wpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_req_type_i,
  input  logic                 cfg_valid_i,
  input  wpa_pkg::wpa_status_t status_i,
  output wpa_pkg::wpa_cmd_t    cmd_o,
  output logic                 s_tready_o,
  output logic                 cfg_ready_o
);
  import wpa_pkg::*;

  wpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    s_tready_o = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        s_tready_o = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
          state_d = ST_SYNC;
        end else if (s_tvalid_i) begin
          if (s_req_type_i == REQ_ALLOC) begin
            cmd_o.load_req = 1'b1;
            state_d = status_i.req_empty ? ST_EMPTY : ST_SCAN;
          end else begin
            cmd_o.release_slot = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.grant_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        cmd_o.emit_empty = 1'b1;
        if (status_i.can_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_SYNC: begin
        cmd_o.sync_step = 1'b1;
        if (status_i.sync_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/wpa_dp.sv =====
// Datapath of the worker pool allocator unit: busy bitmap, counters,
// slot scanner and output register. Depends on wpa_pkg; driven by wpa_ctrl.
module wpa_dp #(
  parameter int unsigned MaxWorkers = wpa_pkg::MAX_WORKERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wpa_pkg::wpa_cmd_t            cmd_i,
  output wpa_pkg::wpa_status_t         status_o,
  input  logic [wpa_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [wpa_pkg::FIELD_W-1:0]  worker_id_i,
  input  logic [wpa_pkg::FIELD_W-1:0]  request_count_i,
  input  logic                         m_tready_i,
  output logic                         m_tvalid_o,
  output logic                         grant_valid_o,
  output logic [wpa_pkg::FIELD_W-1:0]  granted_worker_o,
  output logic [wpa_pkg::FIELD_W-1:0]  granted_total_o,
  output logic [wpa_pkg::FIELD_W-1:0]  free_after_o,
  output logic [wpa_pkg::FIELD_W-1:0]  peak_busy_o,
  output logic                         last_o
);
  import wpa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxWorkers);
  localparam int unsigned CntW = $clog2(MaxWorkers + 1);
  localparam int unsigned WideW = (CntW > CFG_W) ? CntW : CFG_W;

  function automatic logic [CntW-1:0] eff_of(input logic [CFG_W-1:0] wc);
    logic [WideW-1:0] w;
    logic [WideW-1:0] e;
    w = WideW'(wc);
    if (w < WideW'(2)) begin
      e = WideW'(2);
    end else if (w > WideW'(MaxWorkers)) begin
      e = WideW'(MaxWorkers);
    end else begin
      e = w;
    end
    return CntW'(e);
  endfunction

  function automatic logic [MaxWorkers-1:0] slot_mask(input logic [CntW-1:0] cnt);
    logic [MaxWorkers-1:0] m;
    for (int i = 0; i < MaxWorkers; i++) begin
      m[i] = (i != 0) && (WideW'(i) < WideW'(cnt));
    end
    return m;
  endfunction

  logic [CFG_W-1:0]      worker_count_q;
  logic [MaxWorkers-1:0] busy_q;
  logic [CntW-1:0]       free_q;
  logic [CntW-1:0]       peak_q;
  logic [FIELD_W-1:0]    total_q;
  logic [FIELD_W-1:0]    remain_q;
  logic [IdxW-1:0]       idx_q;
  logic                  out_valid_q;

  logic [CntW-1:0]  eff;
  logic [WideW-1:0] free_w;
  logic [WideW-1:0] rc_w;
  logic [WideW-1:0] gnt_w;
  logic [WideW-1:0] free_after_w;
  logic [WideW-1:0] busy_after_w;
  logic [WideW-1:0] wid_w;
  logic             rel_ok;
  logic             slot_free;
  logic             can_load;
  logic             do_grant;
  logic             advance;
  logic             do_empty;

  assign eff = eff_of(worker_count_q);
  assign free_w = WideW'(free_q);
  assign rc_w = WideW'(request_count_i);
  assign gnt_w = (rc_w < free_w) ? rc_w : free_w;
  assign free_after_w = free_w - gnt_w;
  assign busy_after_w = WideW'(eff) - WideW'(1) - free_after_w;
  assign wid_w = WideW'(worker_id_i);
  assign rel_ok = (wid_w != '0) && (wid_w < WideW'(eff)) && busy_q[wid_w[IdxW-1:0]];

  assign slot_free = !busy_q[idx_q];
  assign can_load = !out_valid_q || m_tready_i;
  assign do_grant = cmd_i.scan && slot_free && can_load;
  assign advance = cmd_i.scan && (!slot_free || can_load);
  assign do_empty = cmd_i.emit_empty && can_load;

  assign status_o.req_empty = (gnt_w == '0);
  assign status_o.grant_last = do_grant && (remain_q == FIELD_W'(1));
  assign status_o.sync_last = cmd_i.sync_step
                              && (WideW'(idx_q) == WideW'(eff) - WideW'(1));
  assign status_o.can_load = can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WORKER_COUNT_RST;
      busy_q <= '0;
      free_q <= CntW'(eff_of(WORKER_COUNT_RST) - CntW'(1));
      peak_q <= '0;
      remain_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_write) begin
        worker_count_q <= cfg_data_i;
        busy_q <= busy_q & slot_mask(eff_of(cfg_data_i));
        free_q <= '0;
        idx_q <= IdxW'(1);
      end else if (cmd_i.sync_step) begin
        if (slot_free) begin
          free_q <= free_q + CntW'(1);
        end
        idx_q <= idx_q + IdxW'(1);
      end else if (cmd_i.release_slot) begin
        if (rel_ok) begin
          busy_q[wid_w[IdxW-1:0]] <= 1'b0;
          free_q <= free_q + CntW'(1);
        end
      end else if (cmd_i.load_req) begin
        free_q <= free_after_w[CntW-1:0];
        if (busy_after_w > WideW'(peak_q)) begin
          peak_q <= busy_after_w[CntW-1:0];
        end
        remain_q <= gnt_w[FIELD_W-1:0];
        idx_q <= IdxW'(1);
      end else if (advance) begin
        if (do_grant) begin
          busy_q[idx_q] <= 1'b1;
          remain_q <= remain_q - FIELD_W'(1);
        end
        idx_q <= idx_q + IdxW'(1);
      end

      if (do_grant || do_empty) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      total_q <= gnt_w[FIELD_W-1:0];
    end
    if (do_grant) begin
      grant_valid_o <= 1'b1;
      granted_worker_o <= FIELD_W'(WideW'(idx_q));
      granted_total_o <= total_q;
      free_after_o <= FIELD_W'(free_w);
      peak_busy_o <= FIELD_W'(WideW'(peak_q));
      last_o <= (remain_q == FIELD_W'(1));
    end else if (do_empty) begin
      grant_valid_o <= 1'b0;
      granted_worker_o <= '0;
      granted_total_o <= '0;
      free_after_o <= FIELD_W'(free_w);
      peak_busy_o <= FIELD_W'(WideW'(peak_q));
      last_o <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// ===== rtl/core/worker_pool_allocator_unit.sv =====
// Top level of the worker pool allocator unit: stream ports and config port.
// Depends on wpa_pkg, wpa_ctrl, wpa_dp and worker_pool_allocator_unit_assert.svh.
//
//   Channel   Direction  Transaction
//   s_axis    in         one release or one request for workers
//   m_axis    out        one granted worker, or one empty grant
//   cfg       in         write of worker_count
//
// A release is handled in the idle state. A request is accepted in the idle state, then
// scans slots from slot 1 up to its last grant, at most up to the saturated worker count
// minus one; an empty request skips the scan and emits one empty grant. The slot scanner
// waits at a free slot while the output register holds a result that is not taken.
// A worker_count write is followed by a recount sweep over slots 1 up to the saturated
// worker count minus one. After reset all workers are free and the block is ready at once.
`include "worker_pool_allocator_unit_assert.svh"

module worker_pool_allocator_unit #(
  parameter int unsigned MaxWorkers = wpa_pkg::MAX_WORKERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // worker_id [4:0], request_count [9:5], zeros above.
  input  logic [wpa_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // req_type.
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // granted_worker [4:0], granted_total [9:5], free_after [14:10],
  // peak_busy [19:15], zeros above.
  output logic [wpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // grant_valid.
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpa_pkg::CFG_W-1:0]       cfg_data_i
);
  import wpa_pkg::*;

  wpa_cmd_t           cmd;
  wpa_status_t        status;
  logic [FIELD_W-1:0] granted_worker;
  logic [FIELD_W-1:0] granted_total;
  logic [FIELD_W-1:0] free_after;
  logic [FIELD_W-1:0] peak_busy;

  wpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_req_type_i(s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .s_tready_o  (s_axis_tready_o),
    .cfg_ready_o (cfg_ready_o)
  );

  wpa_dp #(
    .MaxWorkers(MaxWorkers)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_data_i      (cfg_data_i),
    .worker_id_i     (s_axis_tdata_i[FIELD_W-1:0]),
    .request_count_i (s_axis_tdata_i[2*FIELD_W-1:FIELD_W]),
    .m_tready_i      (m_axis_tready_i),
    .m_tvalid_o      (m_axis_tvalid_o),
    .grant_valid_o   (m_axis_tuser_o),
    .granted_worker_o(granted_worker),
    .granted_total_o (granted_total),
    .free_after_o    (free_after),
    .peak_busy_o     (peak_busy),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({peak_busy, free_after, granted_total, granted_worker});

  `WPA_ASSERT_NEVER(a_single_accept, s_axis_tvalid_i && s_axis_tready_o && cfg_valid_i && cfg_ready_o)
  `WPA_ASSERT(a_cfg_blocks_input, (cfg_valid_i && cfg_ready_o) |=> !s_axis_tready_o)
  `WPA_ASSERT(a_empty_is_last, (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
  `WPA_ASSERT(a_total_matches, m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o[9:5] != 5'd0)))

endmodule

// ===== tb/tb_worker_pool_allocator_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for worker_pool_allocator_unit: directed table, then random phases.
// Depends on wpa_pkg and the unit's RTL; predicts every grant with its own bitmap model.
module tb_worker_pool_allocator_unit;

  localparam int MAX_W = wpa_pkg::MAX_WORKERS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic       grant_valid;
    logic [4:0] worker;
    logic [4:0] total;
    logic [4:0] free_after;
    logic [4:0] peak;
    logic       last;
  } grant_t;

  typedef enum logic [1:0] {
    ROW_RELEASE,
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [4:0] worker_id;
    logic [4:0] req_count;
    logic [5:0] cfg_value;
    logic       typed;
    grant_t     result;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [wpa_pkg::IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                           s_axis_tuser_i = 1'b0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b1;
  logic [wpa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                           m_axis_tuser_o;
  logic                           m_axis_tlast_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [wpa_pkg::CFG_W-1:0]      cfg_data_i = '0;

  // Predictor state.
  logic [5:0]       worker_count_m;
  logic [MAX_W-1:0] busy_map;
  int               free_total;
  int               busy_peak;

  grant_t    pending_grants[$];
  stim_row_t dir_rows[$];

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_left = 0;
  int mismatches = 0;
  int items_sent = 0;
  int grants_seen = 0;
  int empties_seen = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  grant_t got;
  grant_t want;

  worker_pool_allocator_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int eff_workers();
    int c;
    c = int'(worker_count_m);
    if (c < 2) c = 2;
    if (c > MAX_W) c = MAX_W;
    return c;
  endfunction

  function automatic logic [MAX_W-1:0] slot_mask(input int c);
    logic [MAX_W-1:0] m;
    m = '0;
    for (int i = 1; i < c; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic grant_t mk_grant(input logic gv, input int w, input int t, input int f,
                                      input int p);
    grant_t g;
    g.grant_valid = gv;
    g.worker = 5'(w);
    g.total = 5'(t);
    g.free_after = 5'(f);
    g.peak = 5'(p);
    g.last = 1'b1;
    return g;
  endfunction

  task automatic recount_pool();
    int c;
    c = eff_workers();
    busy_map &= slot_mask(c);
    free_total = (c - 1) - $countones(busy_map);
  endtask

  // Applies one accepted transaction to the bitmap and queues the grants it causes.
  task automatic allocate_model(input logic rtype, input logic [4:0] wid,
                                input logic [4:0] cnt);
    int c;
    int wanted;
    int n;
    int busy_now;
    logic [4:0] granted[$];
    grant_t g;
    c = eff_workers();
    if (rtype == wpa_pkg::REQ_RELEASE) begin
      if (wid != 0 && int'(wid) < c && busy_map[wid]) begin
        busy_map[wid] = 1'b0;
        free_total++;
      end
    end else begin
      wanted = (int'(cnt) < free_total) ? int'(cnt) : free_total;
      for (int i = 1; i < c && granted.size() < wanted; i++) begin
        if (!busy_map[i]) begin
          busy_map[i] = 1'b1;
          granted.push_back(5'(i));
          free_total--;
        end
      end
      busy_now = $countones(busy_map & slot_mask(c));
      if (busy_now > busy_peak) busy_peak = busy_now;
      n = granted.size();
      if (n == 0) begin
        pending_grants.push_back(mk_grant(1'b0, 0, 0, free_total, busy_peak));
      end else begin
        for (int k = 0; k < n; k++) begin
          g = mk_grant(1'b1, int'(granted[k]), n, free_total, busy_peak);
          g.last = (k == n - 1);
          pending_grants.push_back(g);
        end
      end
    end
  endtask

  task automatic send_item(input logic rtype, input logic [4:0] wid, input logic [4:0] cnt,
                           input logic typed, input grant_t typed_res);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = rtype;
    s_axis_tdata_i = '0;
    s_axis_tdata_i[4:0] = wid;
    s_axis_tdata_i[9:5] = cnt;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    allocate_model(rtype, wid, cnt);
    if (typed) begin
      void'(pending_grants.pop_back());
      pending_grants.push_back(typed_res);
    end
    items_sent++;
    @(negedge clk_i);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // Holds the sender until every queued grant has been taken and the unit has settled.
  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_worker_count(input logic [5:0] value);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    worker_count_m = value;
    recount_pool();
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input int wid, input int cnt, input logic typed,
                         input grant_t res);
    stim_row_t r;
    r.kind = kind;
    r.worker_id = 5'(wid);
    r.req_count = 5'(cnt);
    r.cfg_value = '0;
    r.typed = typed;
    r.result = res;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input int value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.cfg_value = 6'(value);
    dir_rows.push_back(r);
  endtask

  task automatic run_phase(input logic [5:0] cfg_value, input int n_items, input int tx_pct,
                           input int rx_pct, input int hold_at);
    int c;
    int cand;
    int sel;
    logic [4:0] wid;
    logic [4:0] cnt;
    set_worker_count(cfg_value);
    tx_gap_pct = tx_pct;
    rx_stall_pct = rx_pct;
    c = eff_workers();
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) drain_results();
      wid = 5'($urandom_range(0, 31));
      cnt = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 45) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) cnt = 5'($urandom_range(0, 4));
        else if (sel == 9) cnt = 5'd31;
        send_item(wpa_pkg::REQ_ALLOC, wid, cnt, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 99) < 75 && busy_map != '0) begin
          for (int t = 0; t < 16; t++) begin
            cand = $urandom_range(1, c - 1);
            if (busy_map[cand]) begin
              wid = 5'(cand);
              break;
            end
          end
        end
        send_item(wpa_pkg::REQ_RELEASE, wid, cnt, 1'b0, '0);
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_stall_pct == 0) begin
      m_axis_tready_i = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i = 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.grant_valid = m_axis_tuser_o;
      got.worker = m_axis_tdata_o[4:0];
      got.total = m_axis_tdata_o[9:5];
      got.free_after = m_axis_tdata_o[14:10];
      got.peak = m_axis_tdata_o[19:15];
      got.last = m_axis_tlast_o;
      if (got.grant_valid) grants_seen++;
      else empties_seen++;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: valid=%0d worker=%0d total=%0d free=%0d peak=%0d last=%0d",
                   got.grant_valid, got.worker, got.total, got.free_after, got.peak, got.last);
      end else begin
        want = pending_grants.pop_front();
        if (got.grant_valid !== want.grant_valid || got.worker !== want.worker ||
            got.total !== want.total || got.free_after !== want.free_after ||
            got.peak !== want.peak || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch at cycle %0d:", cycle_count);
            $display("  expected valid=%0d worker=%0d total=%0d free=%0d peak=%0d last=%0d",
                     want.grant_valid, want.worker, want.total, want.free_after, want.peak,
                     want.last);
            $display("  actual   valid=%0d worker=%0d total=%0d free=%0d peak=%0d last=%0d",
                     got.grant_valid, got.worker, got.total, got.free_after, got.peak,
                     got.last);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  initial begin
    worker_count_m = wpa_pkg::WORKER_COUNT_RST;
    busy_map = '0;
    busy_peak = 0;
    recount_pool();

    // Reset state, master and double releases, full and empty pools, count changes.
    add_row(ROW_REQUEST, 0, 0, 1'b1, mk_grant(1'b0, 0, 0, 31, 0));
    add_row(ROW_REQUEST, 0, 1, 1'b1, mk_grant(1'b1, 1, 1, 30, 1));
    add_row(ROW_RELEASE, 0, 0, 1'b0, '0);
    add_row(ROW_RELEASE, 1, 0, 1'b0, '0);
    add_row(ROW_RELEASE, 1, 0, 1'b0, '0);
    add_row(ROW_REQUEST, 0, 31, 1'b0, '0);
    add_row(ROW_REQUEST, 31, 5, 1'b1, mk_grant(1'b0, 0, 0, 0, 31));
    add_row(ROW_RELEASE, 31, 31, 1'b0, '0);
    add_row(ROW_RELEASE, 16, 0, 1'b0, '0);
    add_row(ROW_REQUEST, 0, 31, 1'b0, '0);
    add_row(ROW_RELEASE, 21, 0, 1'b0, '0);
    add_cfg(0);
    add_row(ROW_RELEASE, 2, 0, 1'b0, '0);
    add_row(ROW_REQUEST, 0, 1, 1'b1, mk_grant(1'b0, 0, 0, 0, 31));
    add_row(ROW_RELEASE, 1, 0, 1'b0, '0);
    add_row(ROW_REQUEST, 0, 31, 1'b1, mk_grant(1'b1, 1, 1, 0, 31));
    add_cfg(63);
    add_row(ROW_REQUEST, 0, 30, 1'b0, '0);
    add_row(ROW_RELEASE, 31, 0, 1'b0, '0);
    add_cfg(1);
    add_cfg(33);
    add_cfg(2);
    add_row(ROW_RELEASE, 1, 0, 1'b0, '0);
    add_row(ROW_REQUEST, 0, 0, 1'b1, mk_grant(1'b0, 0, 0, 1, 31));
    add_cfg(32);
    add_row(ROW_REQUEST, 0, 2, 1'b0, '0);

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_gap_pct = 20;
    rx_stall_pct = 25;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG)
        set_worker_count(dir_rows[i].cfg_value);
      else
        send_item((dir_rows[i].kind == ROW_REQUEST) ? wpa_pkg::REQ_ALLOC : wpa_pkg::REQ_RELEASE,
                  dir_rows[i].worker_id, dir_rows[i].req_count, dir_rows[i].typed,
                  dir_rows[i].result);
    end

    run_phase(6'($urandom_range(3, 12)), 60, 25, 30, 30);
    run_phase(6'd63, 60, 0, 50, -1);
    run_phase(6'($urandom_range(0, 63)), 60, 40, 0, -1);
    run_phase(6'd2, 60, 15, 20, -1);
    run_phase(6'd32, 60, 0, 0, -1);

    drain_results();
    if (pending_grants.size() != 0) begin
      mismatches += pending_grants.size();
      $display("%0d expected results never arrived", pending_grants.size());
    end
    $display("run covered %0d transactions in and %0d grants plus %0d empty grants out,",
             items_sent, grants_seen, empties_seen);
    $display("across %0d worker count writes including saturated values", cfg_writes);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wpa_pkg.sv
rtl/core/wpa_ctrl.sv
rtl/core/wpa_dp.sv
rtl/core/worker_pool_allocator_unit.sv
tb/tb_worker_pool_allocator_unit.sv
